[rtl/cpnp_pkg.sv]
// ----------------------------------------------------------------------------
// cpnp_pkg
// shared types and codes for the collider pair narrow phase unit
// ----------------------------------------------------------------------------
package cpnp_pkg;

	localparam logic SLOT_FIRST   = 1'b0;
	localparam logic SHAPE_BOX    = 1'b0;
	localparam logic SHAPE_SPHERE = 1'b1;

	localparam logic [30:0] PEN_MAX = 31'h7fff_ffff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_EVAL,
		ST_AXIS,
		ST_SQUARE,
		ST_SQRT,
		ST_CHECK,
		ST_DIV,
		ST_ROUND,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic push;
		logic full;
	} job_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} job_rd_t;

endpackage

[rtl/collider_pair_narrow_phase_unit.sv]
// ----------------------------------------------------------------------------
// collider_pair_narrow_phase_unit
// narrow phase test of one collider pair, box or sphere, fixed point
// ----------------------------------------------------------------------------
// input side is a queue: a request is taken when push is high and full low.
// a request with slot 0 loads the held body and gives no result; slot 1
// tests against the held body and gives one result, or none if nothing is
// held. the held body stays until the next slot 0 request replaces it.
// result side is a queue: the result is on the ports while empty is low
// and is taken when pop is high.
// box-box pairs run through the bounds, overlap and axis states. pairs with
// a sphere run through the bit-serial squaring, the one-bit-a-cycle square
// root and the three divide lanes of the back end; a miss or a near-zero
// distance skips the divide. one pair is in the back end at a time; a short
// job queue lets the front take further requests meanwhile. a stalled
// receiver holds the result register; the back end waits with its next
// result and the job queue then fills.
// reset clears the held body flag, the job queue and the result valid flag.
// ----------------------------------------------------------------------------
module collider_pair_narrow_phase_unit #(
	parameter int COORD_WIDTH      = 32,
	parameter int COORD_FRAC_BITS  = 16,
	parameter int NORMAL_FRAC_BITS = 14,
	parameter int JOB_QUEUE_DEPTH  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        slot,
	input  logic        shape,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] off_x,
	input  logic [31:0] off_y,
	input  logic [31:0] off_z,
	input  logic [30:0] half_x,
	input  logic [30:0] half_y,
	input  logic [30:0] half_z,
	output logic        empty,
	input  logic        pop,
	output logic        colliding,
	output logic [15:0] normal_x,
	output logic [15:0] normal_y,
	output logic [15:0] normal_z,
	output logic [30:0] penetration
);

	localparam int JW = 13 * COORD_WIDTH + 5;

	cpnp_pkg::job_wr_t job_wr;
	cpnp_pkg::job_rd_t job_rd;
	logic [JW-1:0]     wr_data;
	logic [JW-1:0]     rd_data;
	logic              job_full;
	logic              job_empty;

	cpnp_front #(
		.CW (COORD_WIDTH),
		.JW (JW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.slot     (slot),
		.shape    (shape),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.off_x    (off_x),
		.off_y    (off_y),
		.off_z    (off_z),
		.half_x   (half_x),
		.half_y   (half_y),
		.half_z   (half_z),
		.job_full (job_full),
		.job_wr   (job_wr),
		.job_data (wr_data)
	);

	cpnp_queue #(
		.WIDTH (JW),
		.DEPTH (JOB_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_wr),
		.wr_data (wr_data),
		.full    (job_full),
		.rd      (job_rd),
		.empty   (job_empty),
		.rd_data (rd_data)
	);

	cpnp_back #(
		.CW (COORD_WIDTH),
		.CF (COORD_FRAC_BITS),
		.NF (NORMAL_FRAC_BITS),
		.JW (JW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (job_empty),
		.job_data    (rd_data),
		.job_rd      (job_rd),
		.empty       (empty),
		.pop         (pop),
		.colliding   (colliding),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.penetration (penetration)
	);

endmodule

[rtl/cpnp_front.sv]
// ----------------------------------------------------------------------------
// cpnp_front
// takes requests, holds the first body and builds one job per pair
// ----------------------------------------------------------------------------
module cpnp_front #(
	parameter int CW = 32,
	parameter int JW = 13 * 32 + 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   slot,
	input  logic                   shape,
	input  logic [31:0]            pos_x,
	input  logic [31:0]            pos_y,
	input  logic [31:0]            pos_z,
	input  logic [31:0]            off_x,
	input  logic [31:0]            off_y,
	input  logic [31:0]            off_z,
	input  logic [30:0]            half_x,
	input  logic [30:0]            half_y,
	input  logic [30:0]            half_z,
	input  logic                   job_full,
	output cpnp_pkg::job_wr_t      job_wr,
	output logic [JW-1:0]          job_data
);

	logic [2:0][CW+31:0] pos_w;
	logic [2:0][CW+31:0] off_w;
	logic [2:0][CW+30:0] half_w;
	logic [2:0][CW-1:0]  in_pos;
	logic [2:0][CW:0]    in_cen;
	logic [2:0][CW-2:0]  in_half;
	logic                accept;

	logic                held_valid_q;
	logic                held_shape_q;
	logic [2:0][CW-1:0]  held_pos_q;
	logic [2:0][CW:0]    held_cen_q;
	logic [2:0][CW-2:0]  held_half_q;

	logic                held_sph;
	logic                in_sph;
	logic                kind;
	logic                swap;
	logic                ss;
	logic [2:0]          posless;
	logic [2:0][CW:0]    ca;
	logic [2:0][CW:0]    cb;
	logic [2:0][CW-2:0]  ha;
	logic [2:0][CW-2:0]  hb;
	logic [CW-1:0]       rad;

	assign pos_w  = {{{CW{1'b0}}, pos_z}, {{CW{1'b0}}, pos_y}, {{CW{1'b0}}, pos_x}};
	assign off_w  = {{{CW{1'b0}}, off_z}, {{CW{1'b0}}, off_y}, {{CW{1'b0}}, off_x}};
	assign half_w = {{{CW{1'b0}}, half_z}, {{CW{1'b0}}, half_y}, {{CW{1'b0}}, half_x}};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i]  = pos_w[i][CW-1:0];
			in_half[i] = half_w[i][CW-2:0];
			in_cen[i]  = (CW+1)'($signed(pos_w[i][CW-1:0]))
				+ (CW+1)'($signed(off_w[i][CW-1:0]));
		end
	end

	assign full   = job_full;
	assign accept = push && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (accept && slot == cpnp_pkg::SLOT_FIRST) begin
			held_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && slot == cpnp_pkg::SLOT_FIRST) begin
			held_shape_q <= shape;
			held_pos_q   <= in_pos;
			held_cen_q   <= in_cen;
			held_half_q  <= in_half;
		end
	end

	// a box held against a sphere is tested sphere first and negated
	always_comb begin
		held_sph = held_shape_q == cpnp_pkg::SHAPE_SPHERE;
		in_sph   = shape == cpnp_pkg::SHAPE_SPHERE;
		kind     = !held_sph && !in_sph;
		swap     = !held_sph && in_sph;
		ss       = held_sph && in_sph;
		for (int i = 0; i < 3; i++) begin
			posless[i] = $signed(held_pos_q[i]) < $signed(in_pos[i]);
			ca[i] = swap ? in_cen[i] : held_cen_q[i];
			cb[i] = swap ? held_cen_q[i] : in_cen[i];
			ha[i] = swap ? in_half[i] : held_half_q[i];
			hb[i] = ss ? '0 : (swap ? held_half_q[i] : in_half[i]);
		end
		rad = CW'(ha[0]) + (ss ? CW'(in_half[0]) : '0);
	end

	assign job_wr.push = accept && slot != cpnp_pkg::SLOT_FIRST && held_valid_q;
	assign job_wr.full = job_full;
	assign job_data    = {kind, swap, posless, ca, cb, ha, hb, rad};

endmodule

[rtl/cpnp_queue.sv]
// ----------------------------------------------------------------------------
// cpnp_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module cpnp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpnp_pkg::job_wr_t    wr,
	input  logic [WIDTH-1:0]     wr_data,
	output logic                 full,
	input  cpnp_pkg::job_rd_t    rd,
	output logic                 empty,
	output logic [WIDTH-1:0]     rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = cnt_q == CNW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr.push && !full;
	assign do_rd   = rd.pop && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

[rtl/cpnp_back.sv]
// ----------------------------------------------------------------------------
// cpnp_back
// runs one pair test: bounds, overlap or distance, square root, normalize
// ----------------------------------------------------------------------------
module cpnp_back #(
	parameter int CW = 32,
	parameter int CF = 16,
	parameter int NF = 14,
	parameter int JW = 13 * 32 + 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  logic [JW-1:0]       job_data,
	output cpnp_pkg::job_rd_t   job_rd,
	output logic                empty,
	input  logic                pop,
	output logic                colliding,
	output logic [15:0]         normal_x,
	output logic [15:0]         normal_y,
	output logic [15:0]         normal_z,
	output logic [30:0]         penetration
);

	localparam int BW   = CW + 2;
	localparam int MW   = CW + 2;
	localparam int RW   = MW + 1;
	localparam int SQW  = 2 * RW;
	localparam int RMW  = RW + 3;
	localparam int NW   = NF + 2;
	localparam int QW   = NF + 1;
	localparam int PEW  = CW + 33;
	localparam int CNTW = $clog2(RW + NF + 2) + 1;
	localparam int NEAR_ZERO = (2 ** CF + 5000) / 10000;

	cpnp_pkg::back_state_t state_q, state_d;

	logic [JW-1:0]        job_q;
	logic                 j_kind;
	logic                 j_neg;
	logic [2:0]           j_posless;
	logic [2:0][CW:0]     j_ca;
	logic [2:0][CW:0]     j_cb;
	logic [2:0][CW-2:0]   j_ha;
	logic [2:0][CW-2:0]   j_hb;
	logic [CW-1:0]        j_rad;

	logic [CNTW-1:0]      cnt_q;
	logic [2:0][BW-1:0]   lo_a_q, hi_a_q, lo_b_q, hi_b_q;
	logic [2:0]           sep_q;
	logic [2:0][BW-1:0]   ov_q;
	logic [2:0]           dneg_q;
	logic [2:0][MW-1:0]   mag_q;
	logic [2:0][2*MW-1:0] sh_q;
	logic [2:0][MW-1:0]   mr_q;
	logic [SQW-1:0]       acc_q;
	logic [SQW-1:0]       radi_q;
	logic [RMW-1:0]       rem_q;
	logic [RW-1:0]        root_q;
	logic [2:0][RW:0]     dr_q;
	logic [2:0][QW-1:0]   dq_q;

	logic                 res_hit_q;
	logic [2:0][NW-1:0]   res_n_q;
	logic [30:0]          res_pen_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 out_load;

	logic [2:0]           sep_c;
	logic [2:0][BW-1:0]   ov_c;
	logic [2:0]           dneg_c;
	logic [2:0][MW-1:0]   mag_c;
	logic [BW:0]          dval;
	logic [BW-1:0]        cen;
	logic [BW-1:0]        clamp;
	logic [BW:0]          mn;
	logic [BW:0]          mx;
	logic [SQW-1:0]       pp_sum;
	logic [RMW-1:0]       rem_t;
	logic [RMW-1:0]       trial;
	logic                 rge;
	logic [2:0][RW:0]     dt;
	logic [2:0]           dge;
	logic                 hit_c;
	logic                 near_c;
	logic [PEW-1:0]       pen_ext;
	logic [30:0]          pen_sat;
	logic [1:0]           axis;
	logic [PEW-1:0]       ov_ext;
	logic [NW-1:0]        one_n;
	logic [2:0][NW-1:0]   nround;
	logic [2:0][NW-1:0]   nbox;
	logic [2:0][NW+15:0]  n_ext;

	assign {j_kind, j_neg, j_posless, j_ca, j_cb, j_ha, j_hb, j_rad} = job_q;
	assign one_n    = NW'(1) << NF;
	assign out_free = !out_valid_q || pop;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpnp_pkg::ST_IDLE: begin
				if (!job_empty) state_d = cpnp_pkg::ST_BOUNDS;
			end
			cpnp_pkg::ST_BOUNDS: state_d = cpnp_pkg::ST_EVAL;
			cpnp_pkg::ST_EVAL: begin
				state_d = j_kind ? cpnp_pkg::ST_AXIS : cpnp_pkg::ST_SQUARE;
			end
			cpnp_pkg::ST_AXIS: state_d = cpnp_pkg::ST_DONE;
			cpnp_pkg::ST_SQUARE: begin
				if (cnt_q == CNTW'(MW - 1)) state_d = cpnp_pkg::ST_SQRT;
			end
			cpnp_pkg::ST_SQRT: begin
				if (cnt_q == CNTW'(RW - 1)) state_d = cpnp_pkg::ST_CHECK;
			end
			cpnp_pkg::ST_CHECK: begin
				state_d = (!hit_c || near_c) ? cpnp_pkg::ST_DONE : cpnp_pkg::ST_DIV;
			end
			cpnp_pkg::ST_DIV: begin
				if (cnt_q == CNTW'(NF)) state_d = cpnp_pkg::ST_ROUND;
			end
			cpnp_pkg::ST_ROUND: state_d = cpnp_pkg::ST_DONE;
			cpnp_pkg::ST_DONE: begin
				if (out_free) state_d = cpnp_pkg::ST_IDLE;
			end
			default: state_d = cpnp_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		job_rd.pop   = 1'b0;
		job_rd.empty = job_empty;
		out_load     = 1'b0;
		case (state_q)
			cpnp_pkg::ST_IDLE: job_rd.pop = !job_empty;
			cpnp_pkg::ST_DONE: out_load = out_free;
			default: begin
				job_rd.pop = 1'b0;
				out_load   = 1'b0;
			end
		endcase
	end

	// overlap, clamp and distance vector
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sep_c[i] = $signed(hi_a_q[i]) < $signed(lo_b_q[i])
				|| $signed(lo_a_q[i]) > $signed(hi_b_q[i]);
			mn = ($signed(hi_a_q[i]) < $signed(hi_b_q[i]))
				? (BW+1)'($signed(hi_a_q[i])) : (BW+1)'($signed(hi_b_q[i]));
			mx = ($signed(lo_a_q[i]) > $signed(lo_b_q[i]))
				? (BW+1)'($signed(lo_a_q[i])) : (BW+1)'($signed(lo_b_q[i]));
			ov_c[i] = BW'(mn - mx);
			cen = BW'($signed(j_ca[i]));
			if ($signed(cen) < $signed(lo_b_q[i])) begin
				clamp = lo_b_q[i];
			end else if ($signed(cen) > $signed(hi_b_q[i])) begin
				clamp = hi_b_q[i];
			end else begin
				clamp = cen;
			end
			dval = (BW+1)'($signed(cen)) - (BW+1)'($signed(clamp));
			dneg_c[i] = dval[BW];
			mag_c[i] = dval[BW] ? MW'(-dval) : MW'(dval);
		end
	end

	// square, root and divide steps
	always_comb begin
		pp_sum = '0;
		for (int i = 0; i < 3; i++) begin
			pp_sum = pp_sum + (mr_q[i][0] ? SQW'(sh_q[i]) : '0);
		end
		rem_t = {rem_q[RMW-3:0], radi_q[SQW-1 -: 2]};
		trial = RMW'({root_q, 2'b01});
		rge   = rem_t >= trial;
		for (int i = 0; i < 3; i++) begin
			dt[i]  = (cnt_q == '0) ? dr_q[i] : {dr_q[i][RW-1:0], 1'b0};
			dge[i] = dt[i] >= (RW+1)'(root_q);
		end
	end

	// hit test and penetration on the floor distance
	always_comb begin
		hit_c   = (RW+1)'(root_q) < (RW+1)'(j_rad);
		near_c  = root_q <= RW'(NEAR_ZERO);
		pen_ext = PEW'(j_rad) - PEW'(root_q);
		pen_sat = (pen_ext > PEW'(cpnp_pkg::PEN_MAX)) ? cpnp_pkg::PEN_MAX : pen_ext[30:0];
	end

	// least overlap axis and rounded normal
	always_comb begin
		if (ov_q[0] < ov_q[1] && ov_q[0] < ov_q[2]) begin
			axis = 2'd0;
		end else if (ov_q[1] < ov_q[2]) begin
			axis = 2'd1;
		end else begin
			axis = 2'd2;
		end
		ov_ext = PEW'(ov_q[axis]);
		for (int i = 0; i < 3; i++) begin
			nbox[i] = '0;
			if (axis == 2'(i)) begin
				nbox[i] = j_posless[i] ? -one_n : one_n;
			end
			nround[i] = NW'(dq_q[i]) + ((RW+1)'({dr_q[i][RW-1:0], 1'b0})
				>= (RW+1)'(root_q) ? NW'(1) : NW'(0));
			if (nround[i] > one_n) nround[i] = one_n;
			if (dneg_q[i] != j_neg) nround[i] = -nround[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpnp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cpnp_pkg::ST_IDLE: begin
				job_q <= job_data;
			end
			cpnp_pkg::ST_BOUNDS: begin
				for (int i = 0; i < 3; i++) begin
					lo_a_q[i] <= BW'($signed(j_ca[i])) - BW'(j_ha[i]);
					hi_a_q[i] <= BW'($signed(j_ca[i])) + BW'(j_ha[i]);
					lo_b_q[i] <= BW'($signed(j_cb[i])) - BW'(j_hb[i]);
					hi_b_q[i] <= BW'($signed(j_cb[i])) + BW'(j_hb[i]);
				end
			end
			cpnp_pkg::ST_EVAL: begin
				sep_q  <= sep_c;
				ov_q   <= ov_c;
				dneg_q <= dneg_c;
				mag_q  <= mag_c;
				acc_q  <= '0;
				for (int i = 0; i < 3; i++) begin
					sh_q[i] <= (2*MW)'(mag_c[i]);
					mr_q[i] <= mag_c[i];
				end
			end
			cpnp_pkg::ST_AXIS: begin
				res_hit_q <= !(|sep_q);
				res_n_q   <= (|sep_q) ? '0 : nbox;
				res_pen_q <= (|sep_q) ? '0
					: ((ov_ext > PEW'(cpnp_pkg::PEN_MAX)) ? cpnp_pkg::PEN_MAX : ov_ext[30:0]);
			end
			cpnp_pkg::ST_SQUARE: begin
				acc_q <= acc_q + pp_sum;
				for (int i = 0; i < 3; i++) begin
					sh_q[i] <= {sh_q[i][2*MW-2:0], 1'b0};
					mr_q[i] <= {1'b0, mr_q[i][MW-1:1]};
				end
				radi_q <= acc_q + pp_sum;
				rem_q  <= '0;
				root_q <= '0;
			end
			cpnp_pkg::ST_SQRT: begin
				radi_q <= {radi_q[SQW-3:0], 2'b00};
				rem_q  <= rge ? rem_t - trial : rem_t;
				root_q <= {root_q[RW-2:0], rge};
			end
			cpnp_pkg::ST_CHECK: begin
				res_hit_q <= hit_c;
				res_pen_q <= hit_c ? pen_sat : '0;
				res_n_q   <= {NW'(0),
					(hit_c && near_c) ? (j_neg ? -one_n : one_n) : NW'(0),
					NW'(0)};
				for (int i = 0; i < 3; i++) begin
					dr_q[i] <= (RW+1)'(mag_q[i]);
					dq_q[i] <= '0;
				end
			end
			cpnp_pkg::ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					dr_q[i] <= dge[i] ? dt[i] - (RW+1)'(root_q) : dt[i];
					dq_q[i] <= {dq_q[i][QW-2:0], dge[i]};
				end
			end
			cpnp_pkg::ST_ROUND: begin
				res_n_q <= nround;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			colliding   <= res_hit_q;
			normal_x    <= n_ext[0][15:0];
			normal_y    <= n_ext[1][15:0];
			normal_z    <= n_ext[2][15:0];
			penetration <= res_pen_q;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_ext[i] = {{16{res_n_q[i][NW-1]}}, res_n_q[i]};
		end
	end

	assign empty = !out_valid_q;

endmodule

[verif/tb_collider_pair_narrow_phase_unit.sv]
// ----------------------------------------------------------------------------
// tb_collider_pair_narrow_phase_unit
// self-checking bench for the collider pair narrow phase unit
// ----------------------------------------------------------------------------
// a directed table covers the pair types, the extremes and the corner cases,
// then random pairs run under three idle patterns. every result popped is
// compared field by field with a row's given contact or the in-bench model.
// ----------------------------------------------------------------------------
module tb_collider_pair_narrow_phase_unit;

	typedef struct {
		logic        slot;
		logic        shape;
		logic [31:0] pos [3];
		logic [31:0] off [3];
		logic [30:0] half [3];
	} body_req_t;

	typedef struct {
		logic        colliding;
		logic [15:0] nrm [3];
		logic [30:0] pen;
	} contact_t;

	typedef struct {
		body_req_t req;
		bit        typed;
		contact_t  want;
	} stim_row_t;

	localparam longint NEAR_DIST = 7;
	localparam longint UNIT_N    = 64'sd1 << 14;
	localparam int     LIMIT     = 3000000;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [30:0] HONE = 31'h0001_0000;
	localparam logic [30:0] HMAX = 31'h7fff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        slot = 1'b0;
	logic        shape = 1'b0;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] off_x = '0, off_y = '0, off_z = '0;
	logic [30:0] half_x = '0, half_y = '0, half_z = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        colliding;
	logic [15:0] normal_x, normal_y, normal_z;
	logic [30:0] penetration;

	collider_pair_narrow_phase_unit dut (.*);

	always #2 clk = ~clk;

	contact_t  contact_q [$];
	int        errors = 0;
	int        cycles = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	bit        hold_req = 1'b0;
	bit        held_ok = 1'b0;
	body_req_t held_body;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("collider_pair_narrow_phase_unit verification failed");
			$finish;
		end
	end

	function automatic longint center(logic [31:0] p, logic [31:0] o);
		return longint'($signed(p)) + longint'($signed(o));
	endfunction

	function automatic longint floor_len(longint d [3]);
		logic [127:0] s, m;
		logic [63:0]  res, cand;
		s = '0;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			m = 128'(d[i] < 0 ? -d[i] : d[i]);
			s += m * m;
		end
		for (int b = 63; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= s)
				res = cand;
		end
		return longint'(res);
	endfunction

	function automatic void unit_dir(longint d [3], longint dlen, output longint n [3]);
		longint a, q, r;
		if (dlen <= NEAR_DIST) begin
			n[0] = 0; n[1] = UNIT_N; n[2] = 0;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			a = d[i] < 0 ? -d[i] : d[i];
			q = (a << 14) / dlen;
			r = (a << 14) % dlen;
			if (2 * r >= dlen)
				q++;
			if (q > UNIT_N)
				q = UNIT_N;
			n[i] = d[i] < 0 ? -q : q;
		end
	endfunction

	function automatic bit sphere_vs_box(body_req_t s, body_req_t b, output longint n [3],
		output longint pen);
		longint d [3];
		longint c, lo, hi, cl, dlen, rad;
		for (int i = 0; i < 3; i++) begin
			c = center(s.pos[i], s.off[i]);
			lo = center(b.pos[i], b.off[i]) - longint'(b.half[i]);
			hi = center(b.pos[i], b.off[i]) + longint'(b.half[i]);
			cl = c < lo ? lo : (c > hi ? hi : c);
			d[i] = c - cl;
		end
		rad = longint'(s.half[0]);
		dlen = floor_len(d);
		n = '{0, 0, 0};
		pen = 0;
		if (dlen >= rad)
			return 1'b0;
		pen = rad - dlen;
		unit_dir(d, dlen, n);
		return 1'b1;
	endfunction

	function automatic bit pair_contact(body_req_t a, body_req_t b, output contact_t c);
		longint n [3];
		longint d [3];
		longint ov [3];
		longint pen, ca, cb, mina, maxa, minb, maxb, dlen, rsum;
		bit hit;
		int ax;
		n = '{0, 0, 0};
		pen = 0;
		hit = 1'b1;
		if (a.shape == cpnp_pkg::SHAPE_BOX && b.shape == cpnp_pkg::SHAPE_BOX) begin
			for (int i = 0; i < 3; i++) begin
				ca = center(a.pos[i], a.off[i]);
				cb = center(b.pos[i], b.off[i]);
				mina = ca - longint'(a.half[i]); maxa = ca + longint'(a.half[i]);
				minb = cb - longint'(b.half[i]); maxb = cb + longint'(b.half[i]);
				if (maxa < minb || mina > maxb)
					hit = 1'b0;
				ov[i] = (maxa < maxb ? maxa : maxb) - (mina > minb ? mina : minb);
			end
			if (hit) begin
				if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 0;
				else if (ov[1] < ov[2]) ax = 1;
				else ax = 2;
				n[ax] = $signed(a.pos[ax]) < $signed(b.pos[ax]) ? -UNIT_N : UNIT_N;
				pen = ov[ax];
			end
		end else if (a.shape == cpnp_pkg::SHAPE_SPHERE && b.shape == cpnp_pkg::SHAPE_SPHERE)
		begin
			for (int i = 0; i < 3; i++)
				d[i] = center(a.pos[i], a.off[i]) - center(b.pos[i], b.off[i]);
			rsum = longint'(a.half[0]) + longint'(b.half[0]);
			dlen = floor_len(d);
			hit = dlen < rsum;
			if (hit) begin
				pen = rsum - dlen;
				unit_dir(d, dlen, n);
			end
		end else if (a.shape == cpnp_pkg::SHAPE_SPHERE) begin
			hit = sphere_vs_box(a, b, n, pen);
		end else begin
			hit = sphere_vs_box(b, a, n, pen);
			for (int i = 0; i < 3; i++)
				n[i] = -n[i];
		end
		if (!hit) begin
			n = '{0, 0, 0};
			pen = 0;
		end
		if (pen > longint'(cpnp_pkg::PEN_MAX))
			pen = longint'(cpnp_pkg::PEN_MAX);
		if (pen < 0)
			pen = 0;
		c.colliding = hit;
		for (int i = 0; i < 3; i++)
			c.nrm[i] = n[i][15:0];
		c.pen = pen[30:0];
		return 1'b1;
	endfunction

	// updates the held body, returns 1 with the contact when a result is due
	function automatic bit predict_contact(body_req_t r, output contact_t c);
		c = '{1'b0, '{16'd0, 16'd0, 16'd0}, 31'd0};
		if (r.slot == cpnp_pkg::SLOT_FIRST) begin
			held_ok = 1'b1;
			held_body = r;
			return 1'b0;
		end
		if (!held_ok)
			return 1'b0;
		return pair_contact(held_body, r, c);
	endfunction

	task automatic send_request(body_req_t r, bit typed = 1'b0, contact_t want = '{default: '0});
		contact_t c;
		slot <= r.slot; shape <= r.shape;
		pos_x <= r.pos[0]; pos_y <= r.pos[1]; pos_z <= r.pos[2];
		off_x <= r.off[0]; off_y <= r.off[1]; off_z <= r.off[2];
		half_x <= r.half[0]; half_y <= r.half[1]; half_z <= r.half[2];
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (predict_contact(r, c))
			contact_q.push_back(typed ? want : c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			pop <= 1'b0;
			repeat (400) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		contact_t w;
		if (arst_n && !empty && pop) begin
			if (contact_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				w = contact_q.pop_front();
				if (colliding !== w.colliding) begin
					$error("colliding exp %0d got %0d", w.colliding, colliding);
					errors++;
				end
				if (normal_x !== w.nrm[0]) begin
					$error("normal_x exp %h got %h", w.nrm[0], normal_x);
					errors++;
				end
				if (normal_y !== w.nrm[1]) begin
					$error("normal_y exp %h got %h", w.nrm[1], normal_y);
					errors++;
				end
				if (normal_z !== w.nrm[2]) begin
					$error("normal_z exp %h got %h", w.nrm[2], normal_z);
					errors++;
				end
				if (penetration !== w.pen) begin
					$error("penetration exp %h got %h", w.pen, penetration);
					errors++;
				end
			end
		end
	end

	function automatic body_req_t mk(logic sl, logic sh, logic [31:0] px, logic [31:0] py,
		logic [31:0] pz, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
		body_req_t r;
		r.slot = sl; r.shape = sh;
		r.pos = '{px, py, pz}; r.off = '{ox, oy, oz}; r.half = '{hx, hy, hz};
		return r;
	endfunction

	function automatic logic [31:0] near_coord();
		return 32'($signed($urandom_range(0, 524288)) - 262144);
	endfunction

	function automatic body_req_t rand_body(logic sl, bit wild);
		body_req_t r;
		r.slot = sl;
		r.shape = 1'($urandom_range(1));
		for (int i = 0; i < 3; i++) begin
			if (wild) begin
				r.pos[i] = $urandom; r.off[i] = $urandom; r.half[i] = 31'($urandom);
			end else begin
				r.pos[i] = near_coord();
				r.off[i] = 32'($signed($urandom_range(0, 131072)) - 65536);
				r.half[i] = 31'($urandom_range(0, 196608));
			end
		end
		return r;
	endfunction

	stim_row_t table_rows [$];

	function automatic stim_row_t row(body_req_t r, bit typed = 1'b0, logic col = 1'b0,
		logic [15:0] nx = '0, logic [15:0] ny = '0, logic [15:0] nz = '0,
		logic [30:0] pen = '0);
		stim_row_t s;
		s.req = r;
		s.typed = typed;
		s.want = '{col, '{nx, ny, nz}, pen};
		return s;
	endfunction

	initial begin
		body_req_t r;
		int sent;
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, HONE, 0, 0)));
		table_rows.push_back(row(mk(0, cpnp_pkg::SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, HONE, 0, 0)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, HONE, 0, 0),
			1, 1, 16'd0, 16'h4000, 16'd0, 31'h0002_0000));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 100 * ONE, 0, 0, 0, 0, 0,
			HONE, 0, 0), 1, 0));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, ONE + ONE / 2, 0, 0, 0, 0, 0,
			HONE, 0, 0)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, 0, ONE / 2, 0, ONE, 0, 0,
			HONE, HONE, HONE)));
		table_rows.push_back(row(mk(0, cpnp_pkg::SHAPE_BOX, 0, 0, 0, 0, 0, 0,
			HONE, 2 * HONE, 3 * HONE)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, ONE / 2, 0, 0, 0, 0, 0,
			HONE, HONE, HONE)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, 0, -32'sd9 * ONE, 0, 0, 0, 0,
			HONE, HONE, HONE), 1, 0));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, HONE, 0, 0),
			1, 1, 16'd0, 16'hc000, 16'd0, 31'h0001_0000));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, ONE / 4, 0, ONE * 3, 0, 0, 0,
			HONE, 0, 0)));
		table_rows.push_back(row(mk(0, cpnp_pkg::SHAPE_SPHERE, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, HMAX, HMAX, HMAX)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, HMAX, HMAX, HMAX)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, 32'h8000_0000, 0, 32'h7fff_ffff,
			32'h8000_0000, 0, 32'h7fff_ffff, HMAX, 0, HMAX)));
		table_rows.push_back(row(mk(0, cpnp_pkg::SHAPE_BOX, 0, 0, 0, 0, 0, 0,
			HMAX, HMAX, HMAX)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, 0, 0, 0, 0, 0, 0, HMAX, HMAX, HMAX),
			1, 1, 16'd0, 16'd0, 16'h4000, 31'h7fff_ffff));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_BOX, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, HMAX, HMAX, HMAX)));
		table_rows.push_back(row(mk(1, cpnp_pkg::SHAPE_SPHERE, 0, 0, 0, 0, 0, 0,
			HMAX, 0, 0)));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (table_rows[i])
			send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].want);

		// pause until the block drains
		push <= 1'b0;
		wait (contact_q.size() == 0);
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 8 : (phase == 1 ? 57 : 0);
			recv_idle = phase == 0 ? 57 : (phase == 1 ? 8 : 0);
			if (phase == 0)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 500) begin
				if ($urandom_range(99) < 10) begin
					send_request(rand_body(1'($urandom_range(1)), 1'b1));
					sent++;
				end else begin
					r = rand_body(0, 1'b0);
					send_request(r);
					sent++;
					for (int k = $urandom_range(1, 3); k > 0; k--) begin
						r = rand_body(1, 1'b0);
						if ($urandom_range(3) == 0) begin
							r.pos = held_body.pos;
							r.off = held_body.off;
						end
						send_request(r);
						sent++;
					end
				end
			end
		end

		push <= 1'b0;
		wait (contact_q.size() == 0);
		repeat (200) @(negedge clk);
		if (errors == 0 && contact_q.size() == 0)
			$display("collider_pair_narrow_phase_unit verification clean");
		else
			$display("collider_pair_narrow_phase_unit verification failed");
		$finish;
	end

endmodule
